/* rtl/pwc_pkg.sv */
// ----------------------------------------------------------------------------
// pwc_pkg: shared types, constants and helpers for the clamped-term PID
// fixed-point widths, config register codes, clamp and saturation functions
// ----------------------------------------------------------------------------
package pwc_pkg;

    // sample rate is a power of two, so dividing by it is an arithmetic shift
    localparam int SampleRateLog2 = 8;
    localparam int SampleRateHz   = 1 << SampleRateLog2;

    localparam int DataW   = 32;                      // Q16.16 samples and terms
    localparam int GainW   = 16;                      // unsigned Q8.8 gains
    localparam int GainFrac = 8;
    localparam int LimitW  = 31;                      // unsigned Q15.16 limits
    localparam int CfgIdxW = 3;

    // widest value fed to the clamp: error difference times the sample rate
    localparam int ClampW  = DataW + 1 + SampleRateLog2;
    // signed sample times zero-extended gain
    localparam int ProdW   = DataW + GainW + 1;
    localparam int ScaledW = ProdW - GainFrac;
    localparam int SatW    = (ScaledW > ClampW) ? ScaledW : ClampW;
    localparam int SumW    = DataW + 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_P_LIMIT = 3'd3,
        CFG_I_LIMIT = 3'd4,
        CFG_D_LIMIT = 3'd5
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLMP  = 8'b0000_0010,   // clamp proportional error
        S_MULP  = 8'b0000_0100,   // kp product, integral update
        S_MULI  = 8'b0000_1000,   // ki product, derivative clamp
        S_MULD  = 8'b0001_0000,   // kd product
        S_SATD  = 8'b0010_0000,   // last term
        S_ADD   = 8'b0100_0000,   // saturated sum
        S_OUT   = 8'b1000_0000    // result waits for transfer
    } t_state;

    // symmetric clamp to +-lim; result always fits DataW bits
    function automatic logic signed [DataW-1:0] clamp_sym(
        input logic signed [ClampW-1:0] x,
        input logic        [LimitW-1:0] lim
    );
        logic signed [ClampW-1:0] pos;
        logic signed [ClampW-1:0] neg;
        logic signed [ClampW-1:0] res;
        pos = $signed({{(ClampW-LimitW){1'b0}}, lim});
        neg = -pos;
        if (x > pos) begin
            res = pos;
        end else if (x < neg) begin
            res = neg;
        end else begin
            res = x;
        end
        return res[DataW-1:0];
    endfunction

    function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] x);
        logic signed [DataW-1:0] res;
        if ((&x[SatW-1:DataW-1]) || !(|x[SatW-1:DataW-1])) begin
            res = x[DataW-1:0];
        end else if (x[SatW-1]) begin
            res = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            res = {1'b0, {(DataW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* rtl/pid_with_clamped_terms.sv */
// ----------------------------------------------------------------------------
// pid_with_clamped_terms: fixed-point PID with clamped P, I and D terms
// one shared clamp, one shared gain multiplier, a term saturator and a sum saturator under a
// small sequencer; Q16.16 data, unsigned Q8.8 gains
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+----------------------------
//  in      | sink      | i_in_valid / o_in_stall      | i_error_in
//  out     | source    | o_out_valid / i_out_stall    | o_correction, o_p_term,
//          |           |                              | o_i_term, o_d_term
//  cfg     | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  an item passes from transfer through CLMP, MULP, MULI, MULD, SATD and ADD to OUT, then the
//  result is held until it transfers; the next item is taken in the cycle after that;
//  the state sequence follows the three passes through the one gain multiplier
//  synchronous active-low reset clears gains, limits, integral and previous error
//  o_in_stall is high from the transfer in until the result transfers out
// ----------------------------------------------------------------------------
module pid_with_clamped_terms (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [pwc_pkg::DataW-1:0] i_error_in,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [pwc_pkg::DataW-1:0] o_correction,
    output logic signed [pwc_pkg::DataW-1:0] o_p_term,
    output logic signed [pwc_pkg::DataW-1:0] o_i_term,
    output logic signed [pwc_pkg::DataW-1:0] o_d_term,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [pwc_pkg::DataW-1:0]        i_cfg_data
);

    localparam int DataW   = pwc_pkg::DataW;
    localparam int GainW   = pwc_pkg::GainW;
    localparam int LimitW  = pwc_pkg::LimitW;
    localparam int ClampW  = pwc_pkg::ClampW;
    localparam int ProdW   = pwc_pkg::ProdW;
    localparam int ScaledW = pwc_pkg::ScaledW;
    localparam int SatW    = pwc_pkg::SatW;
    localparam int SumW    = pwc_pkg::SumW;
    localparam int Sh      = pwc_pkg::SampleRateLog2;

    pwc_pkg::t_state r_state, n_state;

    logic [GainW-1:0]  r_kp, r_ki, r_kd;
    logic [LimitW-1:0] r_p_limit, r_i_limit, r_d_limit;

    logic signed [DataW-1:0] r_integral, r_prev;
    logic signed [DataW-1:0] r_err;
    logic signed [DataW-1:0] r_opa;
    logic signed [ProdW-1:0] r_prod;
    logic signed [DataW-1:0] r_p_term, r_i_term, r_d_term, r_correction;

    // shared unit inputs
    logic signed [ClampW-1:0] clamp_x;
    logic        [LimitW-1:0] clamp_lim;
    logic signed [DataW-1:0]  clamp_y;
    logic signed [DataW-1:0]  mul_a;
    logic        [GainW-1:0]  mul_g;
    logic signed [ProdW-1:0]  mul_y;
    logic signed [ScaledW-1:0] scaled;
    logic signed [DataW-1:0]  sat_y;
    logic signed [SumW-1:0]   term_sum;
    logic signed [DataW-1:0]  sum_sat;

    logic signed [ClampW-1:0] err_ext, integ_ext, prev_ext, err_div_ext, diff_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != pwc_pkg::S_IDLE);
    assign o_out_valid = (r_state == pwc_pkg::S_OUT);
    assign o_correction = r_correction;
    assign o_p_term     = r_p_term;
    assign o_i_term     = r_i_term;
    assign o_d_term     = r_d_term;

    assign err_ext     = {{(ClampW-DataW){r_err[DataW-1]}}, r_err};
    assign integ_ext   = {{(ClampW-DataW){r_integral[DataW-1]}}, r_integral};
    assign prev_ext    = {{(ClampW-DataW){r_prev[DataW-1]}}, r_prev};
    // floor division by the sample rate
    assign err_div_ext = err_ext >>> Sh;
    // difference times the sample rate, full precision
    assign diff_ext    = (err_ext - prev_ext) <<< Sh;

    always_comb begin
        clamp_x   = err_ext;
        clamp_lim = r_p_limit;
        case (r_state)
            pwc_pkg::S_MULP: begin
                clamp_x   = integ_ext + err_div_ext;
                clamp_lim = r_i_limit;
            end
            pwc_pkg::S_MULI: begin
                clamp_x   = diff_ext;
                clamp_lim = r_d_limit;
            end
            default: begin
                clamp_x   = err_ext;
                clamp_lim = r_p_limit;
            end
        endcase
    end

    assign clamp_y = pwc_pkg::clamp_sym(clamp_x, clamp_lim);

    always_comb begin
        mul_a = r_opa;
        mul_g = r_kp;
        case (r_state)
            pwc_pkg::S_MULI: begin
                mul_a = r_integral;
                mul_g = r_ki;
            end
            pwc_pkg::S_MULD: begin
                mul_a = r_opa;
                mul_g = r_kd;
            end
            default: begin
                mul_a = r_opa;
                mul_g = r_kp;
            end
        endcase
    end

    assign mul_y  = mul_a * $signed({1'b0, mul_g});
    // Q8.8 rescale, floor
    assign scaled = r_prod[ProdW-1:pwc_pkg::GainFrac];
    assign sat_y  = pwc_pkg::sat32({{(SatW-ScaledW){scaled[ScaledW-1]}}, scaled});

    assign term_sum = {{(SumW-DataW){r_p_term[DataW-1]}}, r_p_term}
                    + {{(SumW-DataW){r_i_term[DataW-1]}}, r_i_term}
                    + {{(SumW-DataW){r_d_term[DataW-1]}}, r_d_term};
    assign sum_sat  = pwc_pkg::sat32({{(SatW-SumW){term_sum[SumW-1]}}, term_sum});

    always_comb begin
        n_state = r_state;
        case (r_state)
            pwc_pkg::S_IDLE: if (i_in_valid) n_state = pwc_pkg::S_CLMP;
            pwc_pkg::S_CLMP: n_state = pwc_pkg::S_MULP;
            pwc_pkg::S_MULP: n_state = pwc_pkg::S_MULI;
            pwc_pkg::S_MULI: n_state = pwc_pkg::S_MULD;
            pwc_pkg::S_MULD: n_state = pwc_pkg::S_SATD;
            pwc_pkg::S_SATD: n_state = pwc_pkg::S_ADD;
            pwc_pkg::S_ADD:  n_state = pwc_pkg::S_OUT;
            pwc_pkg::S_OUT:  if (!i_out_stall) n_state = pwc_pkg::S_IDLE;
            default:         n_state = pwc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pwc_pkg::S_IDLE;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_p_limit  <= '0;
            r_i_limit  <= '0;
            r_d_limit  <= '0;
            r_integral <= '0;
            r_prev     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pwc_pkg::CFG_KP:      r_kp      <= i_cfg_data[GainW-1:0];
                    pwc_pkg::CFG_KI:      r_ki      <= i_cfg_data[GainW-1:0];
                    pwc_pkg::CFG_KD:      r_kd      <= i_cfg_data[GainW-1:0];
                    pwc_pkg::CFG_P_LIMIT: r_p_limit <= i_cfg_data[LimitW-1:0];
                    pwc_pkg::CFG_I_LIMIT: r_i_limit <= i_cfg_data[LimitW-1:0];
                    pwc_pkg::CFG_D_LIMIT: r_d_limit <= i_cfg_data[LimitW-1:0];
                    default: ;
                endcase
            end
            if (r_state == pwc_pkg::S_MULP) r_integral <= clamp_y;
            if (r_state == pwc_pkg::S_MULD) r_prev <= r_err;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            pwc_pkg::S_IDLE: begin
                if (i_in_valid) r_err <= i_error_in;
            end
            pwc_pkg::S_CLMP: begin
                r_opa <= clamp_y;
            end
            pwc_pkg::S_MULP: begin
                r_prod <= mul_y;
            end
            pwc_pkg::S_MULI: begin
                r_p_term <= sat_y;
                r_prod   <= mul_y;
                r_opa    <= clamp_y;
            end
            pwc_pkg::S_MULD: begin
                r_i_term <= sat_y;
                r_prod   <= mul_y;
            end
            pwc_pkg::S_SATD: begin
                r_d_term <= sat_y;
            end
            pwc_pkg::S_ADD: begin
                r_correction <= sum_sat;
            end
            default: ;
        endcase
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pid_with_clamped_terms
// feeds error samples through a random-idle driver, predicts the P, I and D
// terms and their saturated sum per sample, and compares every output
// transfer field by field; gains and limits are reloaded between phases
// ----------------------------------------------------------------------------
module tb;

    localparam int DataW          = pwc_pkg::DataW;
    localparam int GainW          = pwc_pkg::GainW;
    localparam int GainFrac       = pwc_pkg::GainFrac;
    localparam int LimitW         = pwc_pkg::LimitW;
    localparam int CfgIdxW        = pwc_pkg::CfgIdxW;
    localparam int SampleRateLog2 = pwc_pkg::SampleRateLog2;
    localparam int SampleRateHz   = pwc_pkg::SampleRateHz;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int IDLE_PCT    = 29;
    localparam int RAND_PHASES = 10;
    localparam int RAND_ITEMS  = 55;
    // indexes past the last register, the block must ignore them
    localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DataW-1:0] correction;
        logic [DataW-1:0] p_term;
        logic [DataW-1:0] i_term;
        logic [DataW-1:0] d_term;
    } pid_terms_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [DataW-1:0]    i_error_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [DataW-1:0]    o_correction;
    logic signed [DataW-1:0]    o_p_term;
    logic signed [DataW-1:0]    o_i_term;
    logic signed [DataW-1:0]    o_d_term;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CfgIdxW-1:0]         i_cfg_index = '0;
    logic [DataW-1:0]           i_cfg_data = '0;

    pid_with_clamped_terms dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers and the loop state
    logic [GainW-1:0]           gain_p = '0, gain_i = '0, gain_d = '0;
    logic [LimitW-1:0]          lim_p = '0, lim_i = '0, lim_d = '0;
    logic signed [DataW-1:0]    integ_acc = '0;
    logic signed [DataW-1:0]    last_err = '0;

    logic [DataW-1:0]   error_feed[$];
    pid_terms_t         pending_terms[$];
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    logic               in_fire = 1'b0;
    logic               steady = 1'b0;
    logic [DataW-1:0]   held_error = '0;

    pwc_pkg::t_cfg_idx reg_order[6] = '{pwc_pkg::CFG_KP, pwc_pkg::CFG_KI, pwc_pkg::CFG_KD,
                                        pwc_pkg::CFG_P_LIMIT, pwc_pkg::CFG_I_LIMIT,
                                        pwc_pkg::CFG_D_LIMIT};

    function automatic longint clip(input longint x, input logic [LimitW-1:0] lim);
        longint l;
        l = longint'(lim);
        if (x > l) return l;
        if (x < -l) return -l;
        return x;
    endfunction

    function automatic longint sat_word(input longint x);
        if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (x < -longint'(32'sh7FFF_FFFF) - 1) return -longint'(32'sh7FFF_FFFF) - 1;
        return x;
    endfunction

    // floor of the Q8.8 rescale is an arithmetic shift
    function automatic longint apply_gain(input longint x, input logic [GainW-1:0] g);
        return sat_word((x * longint'(g)) >>> GainFrac);
    endfunction

    function automatic pid_terms_t pid_terms_for(input logic signed [DataW-1:0] err);
        longint e, isum, dr, pt, it, dt;
        pid_terms_t r;
        e    = longint'(err);
        pt   = apply_gain(clip(e, lim_p), gain_p);
        isum = clip(longint'(integ_acc) + (e >>> SampleRateLog2), lim_i);
        integ_acc = isum[DataW-1:0];
        it   = apply_gain(isum, gain_i);
        dr   = clip((e - longint'(last_err)) * SampleRateHz, lim_d);
        dt   = apply_gain(dr, gain_d);
        last_err = err;
        r.correction = DataW'(sat_word(pt + it + dt));
        r.p_term     = DataW'(pt);
        r.i_term     = DataW'(it);
        r.d_term     = DataW'(dt);
        return r;
    endfunction

    function automatic void check_term(input string label, input logic [DataW-1:0] want,
                                       input logic [DataW-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %h, got %h", label, want, got);
        end
    endfunction

    // driver: new sample at the falling edge once the previous one transferred
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (error_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_error_in <= error_feed.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // monitor: output check first, then prediction for an input transfer
    always @(posedge i_clk) begin
        pid_terms_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL pid_with_clamped_terms");
            $finish;
        end
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_terms.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("output transfer with nothing pending: correction %h", o_correction);
            end else begin
                want = pending_terms.pop_front();
                check_term("correction", want.correction, o_correction);
                check_term("p_term", want.p_term, o_p_term);
                check_term("i_term", want.i_term, o_i_term);
                check_term("d_term", want.d_term, o_d_term);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            pending_terms.push_back(pid_terms_for(i_error_in));
    end

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pwc_pkg::CFG_KP:      gain_p = data[GainW-1:0];
            pwc_pkg::CFG_KI:      gain_i = data[GainW-1:0];
            pwc_pkg::CFG_KD:      gain_d = data[GainW-1:0];
            pwc_pkg::CFG_P_LIMIT: lim_p  = data[LimitW-1:0];
            pwc_pkg::CFG_I_LIMIT: lim_i  = data[LimitW-1:0];
            pwc_pkg::CFG_D_LIMIT: lim_d  = data[LimitW-1:0];
            default: ;
        endcase
    endtask

    // ends right after the last register transfer, valid still high
    task automatic load_settings(input logic [DataW-1:0] v[6], input bit with_spare);
        if (with_spare) begin
            cfg_write(CFG_SPARE_LO, $urandom);
            cfg_write(CFG_SPARE_HI, $urandom);
        end
        for (int k = 0; k < 6; k++)
            cfg_write(reg_order[k], v[k]);
    endtask

    task automatic feed(input logic [DataW-1:0] e);
        error_feed.push_back(e);
        items_sent++;
    endtask

    task automatic release_cfg_and_drain();
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        while (results_seen != items_sent) @(negedge i_clk);
    endtask

    function automatic logic [DataW-1:0] pick_gain_word();
        logic [GainW-1:0] g;
        case ($urandom_range(4))
            0:       g = '0;
            1:       g = '1;
            2:       g = 16'h0100;
            default: g = GainW'($urandom);
        endcase
        return {16'($urandom), g};
    endfunction

    function automatic logic [DataW-1:0] pick_limit_word();
        logic [LimitW-1:0] l;
        case ($urandom_range(5))
            0:       l = '0;
            1:       l = '1;
            2:       l = LimitW'($urandom_range(0, 32'h0100_0000));
            3:       l = LimitW'($urandom_range(0, 32'h0400_0000));
            default: l = LimitW'($urandom);
        endcase
        return {1'($urandom), l};
    endfunction

    function automatic logic [DataW-1:0] pick_error();
        logic [DataW-1:0] e;
        case ($urandom_range(6))
            0:       e = $urandom;
            1:       e = DataW'($signed(21'($urandom)));
            2: begin
                case ($urandom_range(4))
                    0:       e = 32'h7FFF_FFFF;
                    1:       e = 32'h8000_0000;
                    2:       e = 32'h0000_0000;
                    3:       e = 32'hFFFF_FFFF;
                    default: e = 32'h0000_0001;
                endcase
            end
            // a held error winds the integral up to its clamp
            3:       e = held_error;
            default: e = DataW'($signed(26'($urandom)));
        endcase
        held_error = e;
        return e;
    endfunction

    initial begin
        logic [DataW-1:0] v[6];
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // everything at reset: all terms zero, integral held at zero
        @(posedge i_clk);
        feed(32'h7FFF_FFFF);
        feed(32'h8000_0000);
        while (results_seen != items_sent) @(negedge i_clk);

        // unit gains, widest limits: floor rounding and full-range differences
        v = '{32'h0000_0100, 32'h0000_0100, 32'h0000_0100,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_settings(v, 1'b1);
        feed(32'h0000_0001);
        feed(32'hFFFF_FFFF);
        feed(32'hFFFF_FEFF);
        feed(32'h7FFF_FFFF);
        feed(32'h7FFF_FFFF);
        feed(32'h8000_0000);
        feed(32'h8000_0000);
        feed(32'h0000_0000);
        release_cfg_and_drain();

        // largest gains: the P and D terms and the sum saturate
        v = '{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_settings(v, 1'b0);
        feed(32'h7FFF_FFFF);
        feed(32'h8000_0000);
        feed(32'h4000_0000);
        feed(32'hC000_0000);
        release_cfg_and_drain();

        // zero limits force every clamped quantity to zero
        v = '{32'h0000_0100, 32'h0000_0100, 32'h0000_0100,
              32'h8000_0000, 32'h0000_0000, 32'h0000_0000};
        load_settings(v, 1'b0);
        feed(32'h1234_5678);
        feed(32'hFFFF_FFFB);
        release_cfg_and_drain();

        // tight integral clamp both ways, zero derivative gain
        v = '{32'h0000_0080, 32'h0000_FFFF, 32'hABCD_0000,
              32'h0001_0000, 32'h0003_0000, 32'h7FFF_FFFF};
        load_settings(v, 1'b0);
        repeat (3) feed(32'h7FFF_FFFF);
        repeat (3) feed(32'h8000_0000);
        release_cfg_and_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < 3; k++) v[k] = pick_gain_word();
            for (int k = 3; k < 6; k++) v[k] = pick_limit_word();
            load_settings(v, $urandom_range(2) == 0);
            steady = (ph == 3);
            repeat (RAND_ITEMS) feed(pick_error());
            release_cfg_and_drain();
        end
        steady = 1'b0;

        repeat (20) @(posedge i_clk);
        if (pending_terms.size() != 0) begin
            fail_count += pending_terms.size();
            $display("%0d expected results never arrived", pending_terms.size());
        end
        if (fail_count == 0) begin
            $display("PASS pid_with_clamped_terms");
        end else begin
            $display("FAIL pid_with_clamped_terms");
        end
        $finish;
    end

endmodule
